### sv/steic_pkg.sv
// Package for the segment versus triangle edge crossing unit.
// Holds the fixed-point widths, the pipeline constants, the shared types and the
// saturation helpers. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package steic_pkg;

  localparam int unsigned CRD_W      = 32;           // Q16.16 coordinate
  localparam int unsigned DIF_W      = CRD_W + 1;    // exact coordinate difference
  localparam int unsigned Q_W        = 48;           // Q32.16 slope and intercept
  localparam int unsigned WIDE_W     = Q_W + 1;      // sum or difference of two Q32.16
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned NUM_EDGES  = 3;
  localparam int unsigned MAG_W      = 64;           // unsigned magnitude before saturation

  localparam int unsigned DIV_NUM_W  = 64;
  localparam int unsigned DIV_DEN_W  = 49;
  localparam int unsigned DIV_STEPS  = 49;           // quotient bits, one per stage
  localparam int unsigned DIV_HI_W   = DIV_NUM_W - DIV_STEPS;
  localparam int unsigned DIV_LAT    = DIV_STEPS + 2;

  localparam int unsigned MUL_SPLIT  = 24;           // slope magnitude is cut in two halves
  localparam int unsigned MUL_PROD_W = MUL_SPLIT + CRD_W;
  localparam int unsigned MUL_LAT    = 3;

  typedef logic signed [CRD_W-1:0]  crd_t;
  typedef logic signed [DIF_W-1:0]  dif_t;
  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
  localparam crd_t CRD_MAX = {1'b0, {(CRD_W-1){1'b1}}};
  localparam crd_t CRD_MIN = {1'b1, {(CRD_W-1){1'b0}}};
  localparam logic [MAG_W-1:0] MAG_POS_LIM = {{(MAG_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
  localparam logic [MAG_W-1:0] MAG_NEG_LIM = MAG_POS_LIM + MAG_W'(1);

  typedef struct packed {
    crd_t ax, bx, ay, by;
    crd_t [NUM_EDGES-1:0] tx;
    crd_t [NUM_EDGES-1:0] ty;
  } in_t;

  // Values taken from the input that the later stages still need.
  typedef struct packed {
    crd_t ax, ay;
    crd_t slo_x, shi_x, slo_y, shi_y;
    crd_t [NUM_EDGES-1:0] px, py;
    crd_t [NUM_EDGES-1:0] elo_x, ehi_x, elo_y, ehi_y;
    logic svert;
    logic [NUM_EDGES-1:0] evert;
  } side_t;

  typedef struct packed {
    q_t k1;
    q_t [NUM_EDGES-1:0] k2;
  } kset_t;

  typedef struct packed {
    q_t m1;
    q_t [NUM_EDGES-1:0] m2;
  } mset_t;

  typedef struct packed {
    side_t side;
    kset_t k;
    mset_t m;
    logic [NUM_EDGES-1:0] keq;
  } trk_t;

  typedef struct packed {
    side_t side;
    q_t [NUM_EDGES-1:0] x;
    q_t [NUM_EDGES-1:0] m;
    logic [NUM_EDGES-1:0] keq;
  } fin_t;

  function automatic q_t sat_q(wide_t v);
    if (v[WIDE_W-1] != v[WIDE_W-2]) begin
      return v[WIDE_W-1] ? Q_MIN : Q_MAX;
    end
    return q_t'(v[Q_W-1:0]);
  endfunction

  // Signed Q32.16 result from a sign and an unsigned magnitude, with saturation.
  function automatic q_t from_mag(logic neg, logic [MAG_W-1:0] m);
    logic [Q_W-1:0] low;
    low = m[Q_W-1:0];
    if (!neg) begin
      return (m > MAG_POS_LIM) ? Q_MAX : q_t'(low);
    end
    return (m > MAG_NEG_LIM) ? Q_MIN : q_t'(-low);
  endfunction

  function automatic logic [DIF_W-1:0] mag_dif(dif_t v);
    return v[DIF_W-1] ? DIF_W'(-v) : DIF_W'(v);
  endfunction

  function automatic logic [WIDE_W-1:0] mag_wide(wide_t v);
    return v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
  endfunction

  function automatic crd_t clamp_crd(q_t y);
    if ((&y[Q_W-1:CRD_W-1]) || !(|y[Q_W-1:CRD_W-1])) begin
      return crd_t'(y[CRD_W-1:0]);
    end
    return y[Q_W-1] ? CRD_MIN : CRD_MAX;
  endfunction

endpackage

`default_nettype wire

### sv/steic_if.sv
// Valid/ready channel interfaces of the crossing unit: one for the input items
// and one for the results. Depends on steic_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface steic_in_if import steic_pkg::*; ();
  logic valid;
  logic ready;
  crd_t seg_start_x;
  crd_t seg_start_y;
  crd_t seg_end_x;
  crd_t seg_end_y;
  crd_t tri0_x;
  crd_t tri0_y;
  crd_t tri1_x;
  crd_t tri1_y;
  crd_t tri2_x;
  crd_t tri2_y;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
           tri0_x, tri0_y, tri1_x, tri1_y, tri2_x, tri2_y,
    input  ready
  );
  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
           tri0_x, tri0_y, tri1_x, tri1_y, tri2_x, tri2_y,
    output ready
  );
endinterface

interface steic_out_if import steic_pkg::*; ();
  logic valid;
  logic ready;
  logic crossing_found;
  crd_t crossing_x;
  crd_t crossing_y;

  modport source (output valid, crossing_found, crossing_x, crossing_y, input ready);
  modport sink (input valid, crossing_found, crossing_x, crossing_y, output ready);
endinterface

`default_nettype wire

### sv/steic_div.sv
// Pipelined restoring divider: (num / den) with one quotient bit per stage,
// followed by a stage that applies the sign and saturates to Q32.16. Depends on steic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module steic_div import steic_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  input  logic                 neg_i,
  output q_t                   quo_o
);

  logic [DIV_DEN_W-1:0] rem_q [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] low_q [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo_q [DIV_STEPS+1];
  logic [DIV_DEN_W-1:0] den_q [DIV_STEPS+1];
  logic                 neg_q [DIV_STEPS+1];
  logic                 ovf_q [DIV_STEPS+1];
  logic [DIV_DEN_W-1:0] hi_ext;
  q_t                   res_d;
  q_t                   res_q;

  assign hi_ext = DIV_DEN_W'(num_i[DIV_NUM_W-1 -: DIV_HI_W]);

  // A quotient that does not fit in the stage count is flagged up front.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= hi_ext;
      low_q[0] <= num_i[DIV_STEPS-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
      ovf_q[0] <= (hi_ext >= den_i);
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [DIV_DEN_W:0] trial;
    logic [DIV_DEN_W:0] diff;
    logic               fit;

    assign trial = {rem_q[i], low_q[i][DIV_STEPS-1]};
    assign diff  = trial - {1'b0, den_q[i]};
    assign fit   = (trial >= {1'b0, den_q[i]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= fit ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        low_q[i+1] <= {low_q[i][DIV_STEPS-2:0], 1'b0};
        quo_q[i+1] <= {quo_q[i][DIV_STEPS-2:0], fit};
        den_q[i+1] <= den_q[i];
        neg_q[i+1] <= neg_q[i];
        ovf_q[i+1] <= ovf_q[i];
      end
    end
  end

  always_comb begin
    res_d = from_mag(neg_q[DIV_STEPS],
                     ovf_q[DIV_STEPS] ? {MAG_W{1'b1}} : MAG_W'(quo_q[DIV_STEPS]));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign quo_o = res_q;

endmodule

`default_nettype wire

### sv/steic_qmul.sv
// Three-stage Q32.16 by Q16.16 product, truncated toward zero and saturated.
// The slope magnitude is split in two halves so each multiplier stays narrow. Depends on steic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module steic_qmul import steic_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  q_t   k_i,
  input  crd_t x_i,
  output q_t   p_o
);

  logic [Q_W-1:0]        kmag_q;
  logic [CRD_W-1:0]      xmag_q;
  logic                  neg1_q;
  logic [MUL_PROD_W-1:0] ph_q;
  logic [MUL_PROD_W-1:0] pl_q;
  logic                  neg2_q;
  logic [MAG_W-1:0]      sum;
  q_t                    res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kmag_q <= k_i[Q_W-1] ? Q_W'(-k_i) : Q_W'(k_i);
      xmag_q <= x_i[CRD_W-1] ? CRD_W'(-x_i) : CRD_W'(x_i);
      neg1_q <= k_i[Q_W-1] ^ x_i[CRD_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q   <= MUL_PROD_W'(kmag_q[Q_W-1:MUL_SPLIT]) * MUL_PROD_W'(xmag_q);
      pl_q   <= MUL_PROD_W'(kmag_q[MUL_SPLIT-1:0]) * MUL_PROD_W'(xmag_q);
      neg2_q <= neg1_q;
    end
  end

  // High partial product is already scaled by 2^24, so it only moves up by 8.
  assign sum = (MAG_W'(ph_q) << (MUL_SPLIT - FRAC_W)) + MAG_W'(pl_q >> FRAC_W);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= from_mag(neg2_q, sum);
    end
  end

  assign p_o = res_q;

endmodule

`default_nettype wire

### sv/segment_triangle_edge_intersect_unit.sv
// Segment versus triangle edge crossing unit, top level.
// Depends on steic_pkg, steic_if, steic_div and steic_qmul.
//
// Usage: in_i carries one segment A-B and one triangle per beat; out_o returns
// one beat per input beat: crossing_found, and the crossing point in Q16.16
// (zero on a miss). Edges 0-1, 1-2 and 2-0 are tested in parallel and the first
// of them in that order that the segment strictly crosses is reported.
// The datapath passes two 51-stage dividers (slopes, then the intersection x)
// and two 3-stage multipliers.
// Throughput: one beat per cycle when not stalled; results leave in input order.
// Reset clears every valid bit; the datapath holds no state between beats.
// When out_o.ready is low with a result waiting, the whole pipeline holds;
// the input register still takes one beat if it is empty, so in_i.ready only
// drops once that register is full as well.
`timescale 1ns / 1ps
`default_nettype none

module segment_triangle_edge_intersect_unit import steic_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  steic_in_if.sink     in_i,
  steic_out_if.source  out_o
);

  logic en;
  logic v0_q, v1_q, vm_q, vn_q, vf_q, out_vld_q;
  logic [DIV_LAT-1:0] va_q, vc_q;
  logic [MUL_LAT-1:0] vb_q, vd_q;

  in_t   in_q;
  side_t side1_d, side1_q;
  dif_t  sdx_q, sdy_q;
  dif_t  edx_d [NUM_EDGES];
  dif_t  edy_d [NUM_EDGES];
  dif_t  edx_q [NUM_EDGES];
  dif_t  edy_q [NUM_EDGES];

  side_t side_a_q [DIV_LAT];
  q_t    k1_w;
  q_t    k2_w [NUM_EDGES];
  q_t    pk1_w;
  q_t    pk2_w [NUM_EDGES];

  trk_t  trk_b_in;
  trk_t  trk_b_q [MUL_LAT];
  trk_t  trk_m_d, trk_m_q;
  trk_t  trk_n_d, trk_n_q;
  wide_t dm_d [NUM_EDGES];
  wide_t dk_d [NUM_EDGES];
  wide_t dm_q [NUM_EDGES];
  wide_t dk_q [NUM_EDGES];
  trk_t  trk_c_q [DIV_LAT];
  q_t    xs_w [NUM_EDGES];

  fin_t  fin_in;
  q_t    mk [NUM_EDGES];
  crd_t  mx [NUM_EDGES];
  fin_t  fin_d_q [MUL_LAT];
  q_t    pm_w [NUM_EDGES];
  fin_t  fin_f_q;
  q_t    y_f_q [NUM_EDGES];

  logic  out_found_d, out_found_q;
  crd_t  out_x_d, out_x_q, out_y_d, out_y_q;

  // Global advance: everything moves unless a result waits on a stalled receiver.
  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en || !v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q      <= 1'b0;
      v1_q      <= 1'b0;
      va_q      <= '0;
      vb_q      <= '0;
      vm_q      <= 1'b0;
      vn_q      <= 1'b0;
      vc_q      <= '0;
      vd_q      <= '0;
      vf_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (en || !v0_q) begin
        v0_q <= in_i.valid;
      end
      if (en) begin
        v1_q      <= v0_q;
        va_q      <= {va_q[DIV_LAT-2:0], v1_q};
        vb_q      <= {vb_q[MUL_LAT-2:0], va_q[DIV_LAT-1]};
        vm_q      <= vb_q[MUL_LAT-1];
        vn_q      <= vm_q;
        vc_q      <= {vc_q[DIV_LAT-2:0], vn_q};
        vd_q      <= {vd_q[MUL_LAT-2:0], vc_q[DIV_LAT-1]};
        vf_q      <= vd_q[MUL_LAT-1];
        out_vld_q <= vf_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en || !v0_q) begin
      in_q.ax    <= in_i.seg_start_x;
      in_q.ay    <= in_i.seg_start_y;
      in_q.bx    <= in_i.seg_end_x;
      in_q.by    <= in_i.seg_end_y;
      in_q.tx[0] <= in_i.tri0_x;
      in_q.ty[0] <= in_i.tri0_y;
      in_q.tx[1] <= in_i.tri1_x;
      in_q.ty[1] <= in_i.tri1_y;
      in_q.tx[2] <= in_i.tri2_x;
      in_q.ty[2] <= in_i.tri2_y;
    end
  end

  // Differences, vertical flags and the bounding intervals of segment and edges.
  always_comb begin
    side1_d       = '0;
    side1_d.ax    = in_q.ax;
    side1_d.ay    = in_q.ay;
    side1_d.slo_x = (in_q.ax < in_q.bx) ? in_q.ax : in_q.bx;
    side1_d.shi_x = (in_q.ax > in_q.bx) ? in_q.ax : in_q.bx;
    side1_d.slo_y = (in_q.ay < in_q.by) ? in_q.ay : in_q.by;
    side1_d.shi_y = (in_q.ay > in_q.by) ? in_q.ay : in_q.by;
    side1_d.svert = (in_q.ax == in_q.bx);
    for (int e = 0; e < NUM_EDGES; e++) begin
      int f;
      f = (e == NUM_EDGES - 1) ? 0 : e + 1;
      side1_d.px[e]    = in_q.tx[e];
      side1_d.py[e]    = in_q.ty[e];
      side1_d.elo_x[e] = (in_q.tx[e] < in_q.tx[f]) ? in_q.tx[e] : in_q.tx[f];
      side1_d.ehi_x[e] = (in_q.tx[e] > in_q.tx[f]) ? in_q.tx[e] : in_q.tx[f];
      side1_d.elo_y[e] = (in_q.ty[e] < in_q.ty[f]) ? in_q.ty[e] : in_q.ty[f];
      side1_d.ehi_y[e] = (in_q.ty[e] > in_q.ty[f]) ? in_q.ty[e] : in_q.ty[f];
      side1_d.evert[e] = (in_q.tx[e] == in_q.tx[f]);
      edx_d[e]         = dif_t'(in_q.tx[f]) - dif_t'(in_q.tx[e]);
      edy_d[e]         = dif_t'(in_q.ty[f]) - dif_t'(in_q.ty[e]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q <= side1_d;
      sdx_q   <= dif_t'(in_q.bx) - dif_t'(in_q.ax);
      sdy_q   <= dif_t'(in_q.by) - dif_t'(in_q.ay);
      for (int e = 0; e < NUM_EDGES; e++) begin
        edx_q[e] <= edx_d[e];
        edy_q[e] <= edy_d[e];
      end
    end
  end

  // Slopes of the segment and of each of the NUM_EDGES triangle edges.
  steic_div u_div_seg (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (DIV_NUM_W'({mag_dif(sdy_q), {FRAC_W{1'b0}}})),
    .den_i (DIV_DEN_W'(mag_dif(sdx_q))),
    .neg_i (sdy_q[DIF_W-1] ^ sdx_q[DIF_W-1]),
    .quo_o (k1_w)
  );

  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_slope
    steic_div u_div_edge (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (DIV_NUM_W'({mag_dif(edy_q[e]), {FRAC_W{1'b0}}})),
      .den_i (DIV_DEN_W'(mag_dif(edx_q[e]))),
      .neg_i (edy_q[e][DIF_W-1] ^ edx_q[e][DIF_W-1]),
      .quo_o (k2_w[e])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_a_q[0] <= side1_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_a_q[i] <= side_a_q[i-1];
      end
    end
  end

  // Intercept products k * x at the line's own start point.
  steic_qmul u_mul_seg (
    .clk_i (clk_i),
    .en_i  (en),
    .k_i   (k1_w),
    .x_i   (side_a_q[DIV_LAT-1].ax),
    .p_o   (pk1_w)
  );

  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_icpt
    steic_qmul u_mul_edge (
      .clk_i (clk_i),
      .en_i  (en),
      .k_i   (k2_w[e]),
      .x_i   (side_a_q[DIV_LAT-1].px[e]),
      .p_o   (pk2_w[e])
    );
  end

  always_comb begin
    trk_b_in      = '0;
    trk_b_in.side = side_a_q[DIV_LAT-1];
    trk_b_in.k.k1 = k1_w;
    for (int e = 0; e < NUM_EDGES; e++) begin
      trk_b_in.k.k2[e] = k2_w[e];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      trk_b_q[0] <= trk_b_in;
      for (int i = 1; i < MUL_LAT; i++) begin
        trk_b_q[i] <= trk_b_q[i-1];
      end
    end
  end

  always_comb begin
    trk_m_d      = trk_b_q[MUL_LAT-1];
    trk_m_d.m.m1 = sat_q(wide_t'(trk_m_d.side.ay) - wide_t'(pk1_w));
    for (int e = 0; e < NUM_EDGES; e++) begin
      trk_m_d.m.m2[e] = sat_q(wide_t'(trk_m_d.side.py[e]) - wide_t'(pk2_w[e]));
    end
  end

  always_comb begin
    trk_n_d = trk_m_q;
    for (int e = 0; e < NUM_EDGES; e++) begin
      trk_n_d.keq[e] = (trk_m_q.k.k1 == trk_m_q.k.k2[e]);
      dm_d[e]        = wide_t'(trk_m_q.m.m2[e]) - wide_t'(trk_m_q.m.m1);
      dk_d[e]        = wide_t'(trk_m_q.k.k1) - wide_t'(trk_m_q.k.k2[e]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      trk_m_q <= trk_m_d;
      trk_n_q <= trk_n_d;
      for (int e = 0; e < NUM_EDGES; e++) begin
        dm_q[e] <= dm_d[e];
        dk_q[e] <= dk_d[e];
      end
    end
  end

  // Intersection x of two sloped lines: (m2 - m1) / (k1 - k2).
  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_cross
    logic [WIDE_W-1:0] dm_mag;

    assign dm_mag = mag_wide(dm_q[e]);

    steic_div u_div_x (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (DIV_NUM_W'({dm_mag[Q_W-1:0], {FRAC_W{1'b0}}})),
      .den_i (DIV_DEN_W'(mag_wide(dk_q[e]))),
      .neg_i (dm_q[e][WIDE_W-1] ^ dk_q[e][WIDE_W-1]),
      .quo_o (xs_w[e])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      trk_c_q[0] <= trk_n_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        trk_c_q[i] <= trk_c_q[i-1];
      end
    end
  end

  // Pick the line and the x at which y is evaluated for each edge.
  always_comb begin
    fin_in      = '0;
    fin_in.side = trk_c_q[DIV_LAT-1].side;
    fin_in.keq  = trk_c_q[DIV_LAT-1].keq;
    for (int e = 0; e < NUM_EDGES; e++) begin
      if (trk_c_q[DIV_LAT-1].side.svert) begin
        mk[e]          = trk_c_q[DIV_LAT-1].k.k2[e];
        mx[e]          = trk_c_q[DIV_LAT-1].side.ax;
        fin_in.x[e]    = q_t'(trk_c_q[DIV_LAT-1].side.ax);
        fin_in.m[e]    = trk_c_q[DIV_LAT-1].m.m2[e];
      end else if (trk_c_q[DIV_LAT-1].side.evert[e]) begin
        mk[e]          = trk_c_q[DIV_LAT-1].k.k1;
        mx[e]          = trk_c_q[DIV_LAT-1].side.px[e];
        fin_in.x[e]    = q_t'(trk_c_q[DIV_LAT-1].side.px[e]);
        fin_in.m[e]    = trk_c_q[DIV_LAT-1].m.m1;
      end else begin
        mk[e]          = trk_c_q[DIV_LAT-1].k.k1;
        mx[e]          = crd_t'(xs_w[e][CRD_W-1:0]);
        fin_in.x[e]    = xs_w[e];
        fin_in.m[e]    = trk_c_q[DIV_LAT-1].m.m1;
      end
    end
  end

  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_yval
    steic_qmul u_mul_y (
      .clk_i (clk_i),
      .en_i  (en),
      .k_i   (mk[e]),
      .x_i   (mx[e]),
      .p_o   (pm_w[e])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_d_q[0] <= fin_in;
      for (int i = 1; i < MUL_LAT; i++) begin
        fin_d_q[i] <= fin_d_q[i-1];
      end
      fin_f_q <= fin_d_q[MUL_LAT-1];
      for (int e = 0; e < NUM_EDGES; e++) begin
        y_f_q[e] <= sat_q(wide_t'(pm_w[e]) + wide_t'(fin_d_q[MUL_LAT-1].m[e]));
      end
    end
  end

  // Strict bound tests per edge, then the first edge in order wins.
  always_comb begin
    logic hit;
    logic in_ex, in_sx, in_ey, in_sy;
    out_found_d = 1'b0;
    out_x_d     = '0;
    out_y_d     = '0;
    for (int e = 0; e < NUM_EDGES; e++) begin
      in_ex = (fin_f_q.x[e] > q_t'(fin_f_q.side.elo_x[e])) &&
              (fin_f_q.x[e] < q_t'(fin_f_q.side.ehi_x[e]));
      in_sx = (fin_f_q.x[e] > q_t'(fin_f_q.side.slo_x)) &&
              (fin_f_q.x[e] < q_t'(fin_f_q.side.shi_x));
      in_ey = (y_f_q[e] > q_t'(fin_f_q.side.elo_y[e])) &&
              (y_f_q[e] < q_t'(fin_f_q.side.ehi_y[e]));
      in_sy = (y_f_q[e] > q_t'(fin_f_q.side.slo_y)) &&
              (y_f_q[e] < q_t'(fin_f_q.side.shi_y));
      if (fin_f_q.side.svert && fin_f_q.side.evert[e]) begin
        hit = 1'b0;
      end else if (fin_f_q.side.svert) begin
        hit = in_ex && in_sy;
      end else if (fin_f_q.side.evert[e]) begin
        hit = in_ey && in_sx;
      end else begin
        hit = !fin_f_q.keq[e] && in_ex && in_sx;
      end
      if (hit && !out_found_d) begin
        out_found_d = 1'b1;
        out_x_d     = crd_t'(fin_f_q.x[e][CRD_W-1:0]);
        out_y_d     = clamp_crd(y_f_q[e]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_found_q <= out_found_d;
      out_x_q     <= out_x_d;
      out_y_q     <= out_y_d;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.crossing_found = out_found_q;
  assign out_o.crossing_x     = out_x_q;
  assign out_o.crossing_y     = out_y_q;

endmodule

`default_nettype wire

### test/tb_segment_triangle_edge_intersect_unit.sv
// Testbench for segment_triangle_edge_intersect_unit: directed table, then random beats,
// each result checked against its typed row or a bit-exact Q16.16 crossing predictor.
// Depends on steic_pkg, steic_if and the RTL of the unit.
`timescale 1ns / 1ps

module tb_segment_triangle_edge_intersect_unit;
  import steic_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned NUM_RANDOM  = 500;
  localparam int unsigned TAIL_CYCLES = 250;
  localparam longint      Q48_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      Q48_MIN     = -64'sh0000_7FFF_FFFF_FFFF - 1;
  localparam crd_t        ONE         = 32'sh0001_0000;

  typedef struct packed {
    crd_t ax, ay, bx, by;
    crd_t t0x, t0y, t1x, t1y, t2x, t2y;
  } seg_tri_t;

  typedef struct packed {
    logic found;
    crd_t x;
    crd_t y;
  } crossing_t;

  typedef struct packed {
    seg_tri_t  item;
    logic      typed;
    crossing_t want;
  } row_t;

  logic clk_i;
  logic rst_ni;
  int unsigned cycles;
  int unsigned errors;
  bit quiet;
  crossing_t pending_q[$];

  steic_in_if  in_bus ();
  steic_out_if out_bus ();

  segment_triangle_edge_intersect_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk_i = ~clk_i;

  // ---------------- crossing predictor ----------------
  function automatic longint unsigned mag64(longint v);
    return (v < 0) ? (64'd0 - longint'(v)) : v;
  endfunction

  function automatic longint from_mag48(bit neg, longint unsigned m);
    if (!neg) begin
      return (m > longint'(Q48_MAX)) ? Q48_MAX : longint'(m);
    end
    if (m > longint'(Q48_MAX) + 1) begin
      return Q48_MIN;
    end
    return -longint'(m);
  endfunction

  function automatic longint sat48(longint v);
    if (v > Q48_MAX) return Q48_MAX;
    if (v < Q48_MIN) return Q48_MIN;
    return v;
  endfunction

  function automatic longint q_divide(longint num, longint den);
    longint unsigned q;
    q = (mag64(num) << 16) / mag64(den);
    return from_mag48((num < 0) != (den < 0), q);
  endfunction

  function automatic longint q_scale(longint k, longint x);
    longint unsigned m, n, r;
    m = mag64(k);
    n = mag64(x);
    r = (((m >> 24) * n) << 8) + (((m & 64'hFF_FFFF) * n) >> 16);
    return from_mag48((k < 0) != (x < 0), r);
  endfunction

  function automatic longint min64(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint max64(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic bit edge_crossing(longint ax, longint ay, longint bx, longint by,
                                       longint px, longint py, longint qx, longint qy,
                                       output longint vx, output longint vy);
    longint sdx, edx, k1, k2, m1, m2, x, y;
    sdx = bx - ax;
    edx = qx - px;
    vx = 0;
    vy = 0;
    if (sdx == 0 && edx == 0) return 1'b0;
    if (sdx == 0) begin
      k2 = q_divide(qy - py, edx);
      m2 = sat48(py - q_scale(k2, px));
      x = ax;
      y = sat48(q_scale(k2, x) + m2);
      if (!(x > min64(px, qx) && x < max64(px, qx) && y > min64(ay, by) && y < max64(ay, by)))
        return 1'b0;
    end else if (edx == 0) begin
      k1 = q_divide(by - ay, sdx);
      m1 = sat48(ay - q_scale(k1, ax));
      x = px;
      y = sat48(q_scale(k1, x) + m1);
      if (!(y > min64(py, qy) && y < max64(py, qy) && x > min64(ax, bx) && x < max64(ax, bx)))
        return 1'b0;
    end else begin
      k1 = q_divide(by - ay, sdx);
      k2 = q_divide(qy - py, edx);
      if (k1 == k2) return 1'b0;
      m1 = sat48(ay - q_scale(k1, ax));
      m2 = sat48(py - q_scale(k2, px));
      x = q_divide(m2 - m1, k1 - k2);
      if (!(x > min64(px, qx) && x < max64(px, qx) && x > min64(ax, bx) && x < max64(ax, bx)))
        return 1'b0;
      y = sat48(q_scale(k1, x) + m1);
    end
    if (y > 64'sd2147483647) y = 64'sd2147483647;
    if (y < -64'sd2147483648) y = -64'sd2147483648;
    vx = x;
    vy = y;
    return 1'b1;
  endfunction

  function automatic crossing_t predict_crossing(seg_tri_t s);
    longint tx[3], ty[3];
    longint vx, vy;
    crossing_t r;
    tx[0] = s.t0x; ty[0] = s.t0y;
    tx[1] = s.t1x; ty[1] = s.t1y;
    tx[2] = s.t2x; ty[2] = s.t2y;
    r = '0;
    for (int e = 0; e < 3; e++) begin
      if (!r.found && edge_crossing(s.ax, s.ay, s.bx, s.by, tx[e], ty[e],
                                    tx[(e + 1) % 3], ty[(e + 1) % 3], vx, vy)) begin
        r.found = 1'b1;
        r.x = crd_t'(vx);
        r.y = crd_t'(vy);
      end
    end
    return r;
  endfunction

  // ---------------- stimulus ----------------
  function automatic crd_t near(int unsigned span);
    return crd_t'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  function automatic seg_tri_t random_item();
    seg_tri_t s;
    int unsigned span;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    case ($urandom_range(0, 3))
      0: span = 32'd256;
      1: span = 32'd65536;
      2: span = 32'd1048576;
      default: span = 32'd16777216;
    endcase
    s = {near(span), near(span), near(span), near(span), near(span),
         near(span), near(span), near(span), near(span), near(span)};
    case (mode)
      0, 1: s = {$urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom};
      2: s.bx = s.ax;
      3: s.t1x = s.t0x;
      4: begin
        s.bx = s.ax;
        s.t2x = s.t1x;
      end
      default: begin
        // Segment x coordinates span twice the triangle's range.
        s.ax = near(span) <<< 1;
        s.bx = near(span) <<< 1;
      end
    endcase
    return s;
  endfunction

  task automatic send_beat(seg_tri_t s, logic typed, crossing_t want);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.seg_start_x <= s.ax;
    in_bus.seg_start_y <= s.ay;
    in_bus.seg_end_x   <= s.bx;
    in_bus.seg_end_y   <= s.by;
    in_bus.tri0_x      <= s.t0x;
    in_bus.tri0_y      <= s.t0y;
    in_bus.tri1_x      <= s.t1x;
    in_bus.tri1_y      <= s.t1y;
    in_bus.tri2_x      <= s.t2x;
    in_bus.tri2_y      <= s.t2y;
    forever begin
      @(negedge clk_i);
      if (in_bus.ready) break;
    end
    pending_q.push_back(typed ? want : predict_crossing(s));
    @(posedge clk_i);
  endtask

  // Result sink: random stall bursts, none in the quiet part.
  int unsigned stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      stall_left = 0;
    end else if (quiet) begin
      out_bus.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_bus.ready <= 1'b0;
      stall_left = $urandom_range(0, 16);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    crossing_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_q.size() == 0) begin
        $error("result beat with no expectation waiting");
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_bus.crossing_found !== want.found) begin
          $error("crossing_found: expected %0d, got %0d", want.found, out_bus.crossing_found);
          errors++;
        end
        if (out_bus.crossing_x !== want.x) begin
          $error("crossing_x: expected %h, got %h", want.x, out_bus.crossing_x);
          errors++;
        end
        if (out_bus.crossing_y !== want.y) begin
          $error("crossing_y: expected %h, got %h", want.y, out_bus.crossing_y);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  row_t directed[$];

  initial begin
    crossing_t miss;
    seg_tri_t s;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cycles = 0;
    errors = 0;
    quiet = 1'b0;
    in_bus.valid = 1'b0;
    {in_bus.seg_start_x, in_bus.seg_start_y, in_bus.seg_end_x, in_bus.seg_end_y,
     in_bus.tri0_x, in_bus.tri0_y, in_bus.tri1_x, in_bus.tri1_y,
     in_bus.tri2_x, in_bus.tri2_y} = '0;
    miss = '0;

    directed.push_back('{'0, 1'b1, miss});
    directed.push_back('{{10{CRD_MAX}}, 1'b1, miss});
    directed.push_back('{{10{CRD_MIN}}, 1'b1, miss});
    // Vertical segment through a horizontal edge at the origin.
    directed.push_back('{{32'sd0, -10 * ONE, 32'sd0, 10 * ONE,
                          -5 * ONE, 32'sd0, 5 * ONE, 32'sd0, 32'sd0, 20 * ONE},
                         1'b1, '{1'b1, 32'sd0, 32'sd0}});
    // Both vertical on edge 0-1, crossing on a later edge.
    directed.push_back('{{ONE, -10 * ONE, ONE, 10 * ONE,
                          3 * ONE, -5 * ONE, 3 * ONE, 5 * ONE, -4 * ONE, 32'sd0}, 1'b0, miss});
    // Parallel sloped lines.
    directed.push_back('{{32'sd0, 32'sd0, 4 * ONE, 4 * ONE,
                          32'sd0, ONE, 4 * ONE, 5 * ONE, 9 * ONE, 9 * ONE}, 1'b0, miss});
    // Vertical edge against a sloped segment.
    directed.push_back('{{-8 * ONE, -3 * ONE, 8 * ONE, 5 * ONE,
                          2 * ONE, -9 * ONE, 2 * ONE, 9 * ONE, 7 * ONE, 30 * ONE}, 1'b0, miss});
    // Generic sloped crossing on edge 1-2.
    directed.push_back('{{-7 * ONE, 3 * ONE, 9 * ONE, -2 * ONE,
                          -1 * ONE, 20 * ONE, 2 * ONE, 8 * ONE, 5 * ONE, -9 * ONE}, 1'b0, miss});
    // Zero-length segment and zero-length edge.
    directed.push_back('{{ONE, ONE, ONE, ONE, 32'sd0, 32'sd0, 3 * ONE, 3 * ONE,
                          32'sd0, 5 * ONE}, 1'b0, miss});
    directed.push_back('{{-3 * ONE, 32'sd0, 3 * ONE, 32'sd1, ONE, ONE, ONE, ONE,
                          ONE, -ONE}, 1'b0, miss});
    // Extreme spans: steep slopes and y saturation.
    directed.push_back('{{CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, 32'sd0, CRD_MAX,
                          32'sd1, CRD_MIN, CRD_MAX, 32'sd0}, 1'b0, miss});
    directed.push_back('{{32'sd0, CRD_MIN, 32'sd1, CRD_MAX, CRD_MIN, CRD_MAX,
                          CRD_MAX, CRD_MIN, CRD_MIN, 32'sd0}, 1'b0, miss});
    directed.push_back('{{CRD_MIN, 32'sd0, CRD_MAX, 32'sd0, -32'sd1, CRD_MIN,
                          32'sd1, CRD_MAX, 32'sd0, CRD_MAX}, 1'b0, miss});
    directed.push_back('{{CRD_MAX, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, CRD_MAX,
                          CRD_MIN, CRD_MIN, 32'sd0, CRD_MIN}, 1'b0, miss});
    directed.push_back('{{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                          32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                          32'h0F0F_0F0F, 32'hF0F0_F0F0}, 1'b0, miss});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_beat(directed[i].item, directed[i].typed, directed[i].want);
    end

    for (int unsigned n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 3) begin
        // Let the pipeline run dry before sending on.
        in_bus.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk_i);
      end
      if (n == NUM_RANDOM * 4 / 5) quiet = 1'b1;
      s = random_item();
      send_beat(s, 1'b0, miss);
    end
    in_bus.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
